/* src/dnsqe_pkg.sv */
`timescale 1ns / 1ps

package dnsqe_pkg;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam int         HDR_LEN  = 12;
  localparam int         TRL_LEN  = 5;
  localparam int         MAX_RES  = 64;
  localparam int         SEQ_W    = 4;
  localparam int         RES_W    = $clog2(MAX_RES + 1);

  // header and trailer field offsets
  localparam logic [SEQ_W-1:0] HDR_ID_HI   = 4'd0;
  localparam logic [SEQ_W-1:0] HDR_ID_LO   = 4'd1;
  localparam logic [SEQ_W-1:0] HDR_FLAGS   = 4'd2;
  localparam logic [SEQ_W-1:0] HDR_QD_LO   = 4'd5;
  localparam logic [SEQ_W-1:0] TRL_TYPE_LO = 4'd2;
  localparam logic [SEQ_W-1:0] TRL_CLS_LO  = 4'd4;

  localparam logic [7:0] FLAG_RD   = 8'h01;
  localparam logic [7:0] QDCOUNT   = 8'h01;
  localparam logic [7:0] TYPE_A    = 8'h01;
  localparam logic [7:0] CLASS_IN  = 8'h01;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HDR   = 5'b00010,
    ST_LEN   = 5'b00100,
    ST_DATA  = 5'b01000,
    ST_TRAIL = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [7:0] hdr_byte(input logic [SEQ_W-1:0] idx,
                                          input logic [15:0] id);
    logic [7:0] b;
    begin
      case (idx)
        HDR_ID_HI: b = id[15:8];
        HDR_ID_LO: b = id[7:0];
        HDR_FLAGS: b = FLAG_RD;
        HDR_QD_LO: b = QDCOUNT;
        default:   b = 8'h00;
      endcase
      return b;
    end
  endfunction

  // terminating root byte, then QTYPE and QCLASS
  function automatic logic [7:0] trl_byte(input logic [SEQ_W-1:0] idx);
    logic [7:0] b;
    begin
      case (idx)
        TRL_TYPE_LO: b = TYPE_A;
        TRL_CLS_LO:  b = CLASS_IN;
        default:     b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

/* src/dnsqe_cell.sv */
`timescale 1ns / 1ps

module dnsqe_cell import dnsqe_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] char_in,
  input  logic [7:0] next_in,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= char_in;
    end else if (ctrl.shift) begin
      q <= next_in;
    end
  end

endmodule

/* src/dns_query_name_encoder_core.sv */
`timescale 1ns / 1ps
// DNS query encoder. Host name characters come in on the input channel
// (name_char, name_end, query_id); message bytes leave on the output channel
// (out_byte, packet_end, label_overflow), both valid/ready.
// The first character of a name starts a 12-byte header built from query_id.
// Ordinary characters are held in a chain of byte cells, one cell per label
// position; a dot or the end of the name drains the chain head first, after
// a length byte, one byte per cycle unless the receiver stalls. The last
// character then adds the root zero byte and QTYPE A / QCLASS IN; packet_end
// marks the final byte. A character that emits nothing leaves the encoder
// idle, so such characters are taken back to back. For one that produces
// bytes, the sequencer feeds the single output register one byte a cycle
// unless the receiver stalls. A step emits at most 64 bytes; any beyond are
// dropped, and in the last character's step packet_end marks the 64th.
// Reset: empty label, no header sent, output empty. When the receiver stalls
// the word is held in the output register and the sequencer waits; new
// characters are refused until the current one has been fully emitted.
module dns_query_name_encoder_core import dnsqe_pkg::*; #(
  parameter int LABEL_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  name_char,
  input  logic        name_end,
  input  logic [15:0] query_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        packet_end,
  output logic        label_overflow
);

  localparam int CW = $clog2(LABEL_MAX + 1);

  state_t           state;
  logic [CW-1:0]    label_count;
  logic             header_sent;
  logic             overflow_seen;
  logic             flush_dot;
  logic             last_q;
  logic [15:0]      id_q;
  logic [SEQ_W-1:0] seq;
  logic [RES_W-1:0] res_cnt;

  logic             accept;
  logic             is_dot;
  logic             can_store;
  logic             slot_free;
  logic             drop;
  logic             adv;
  logic             emitting;
  logic             busy;
  logic [7:0]       cur_byte;
  logic             cur_end;
  state_t           after_hdr;
  state_t           after_flush;

  logic [7:0]       cell_q [LABEL_MAX];

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_dot    = (name_char == DOT_CHAR);
  assign can_store = (label_count < CW'(LABEL_MAX));
  assign slot_free = !out_valid || out_ready;
  assign drop      = (res_cnt == RES_W'(MAX_RES));
  assign busy      = (state != ST_IDLE);
  assign adv       = busy && (drop || slot_free);
  assign emitting  = busy && slot_free && !drop;

  always_comb begin
    if (flush_dot || last_q) begin
      after_hdr = ST_LEN;
    end else begin
      after_hdr = ST_IDLE;
    end
    if (flush_dot) begin
      after_flush = last_q ? ST_LEN : ST_IDLE;
    end else begin
      after_flush = ST_TRAIL;
    end
  end

  always_comb begin
    case (state)
      ST_HDR:   cur_byte = hdr_byte(seq, id_q);
      ST_LEN:   cur_byte = 8'(label_count);
      ST_DATA:  cur_byte = cell_q[0];
      ST_TRAIL: cur_byte = trl_byte(seq);
      default:  cur_byte = 8'h00;
    endcase
    // final trailer byte, or the last byte that fits in the last character's step
    cur_end = ((state == ST_TRAIL) && (seq == SEQ_W'(TRL_LEN - 1)))
           || (last_q && (res_cnt == RES_W'(MAX_RES - 1)));
  end

  genvar i;
  generate
    for (i = 0; i < LABEL_MAX; i++) begin : g_cell
      cell_ctrl_t ctrl;
      logic [7:0] next_in;
      always_comb begin
        ctrl.load  = accept && !is_dot && can_store && (label_count == CW'(i));
        ctrl.shift = (state == ST_DATA) && adv;
      end
      if (i == LABEL_MAX - 1) begin : g_tail
        assign next_in = 8'h00;
      end else begin : g_mid
        assign next_in = cell_q[i+1];
      end
      dnsqe_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .char_in (name_char),
        .next_in (next_in),
        .q       (cell_q[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      label_count   <= '0;
      header_sent   <= 1'b0;
      overflow_seen <= 1'b0;
      flush_dot     <= 1'b0;
      last_q        <= 1'b0;
      seq           <= '0;
      res_cnt       <= '0;
    end else begin
      if (adv && !drop) begin
        res_cnt <= res_cnt + RES_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q    <= name_end;
            flush_dot <= is_dot;
            id_q      <= query_id;
            res_cnt   <= '0;
            seq       <= '0;
            if (!is_dot) begin
              if (can_store) begin
                label_count <= label_count + CW'(1);
              end else begin
                overflow_seen <= 1'b1;
              end
            end
            if (!header_sent) begin
              header_sent <= 1'b1;
              state       <= ST_HDR;
            end else if (is_dot || name_end) begin
              state <= ST_LEN;
            end
          end
        end
        ST_HDR: begin
          if (adv) begin
            if (seq == SEQ_W'(HDR_LEN - 1)) begin
              seq   <= '0;
              state <= after_hdr;
            end else begin
              seq <= seq + SEQ_W'(1);
            end
          end
        end
        ST_LEN: begin
          if (adv) begin
            if (label_count == '0) begin
              flush_dot <= 1'b0;
              state     <= after_flush;
            end else begin
              state <= ST_DATA;
            end
          end
        end
        ST_DATA: begin
          if (adv) begin
            label_count <= label_count - CW'(1);
            if (label_count == CW'(1)) begin
              flush_dot <= 1'b0;
              state     <= after_flush;
            end
          end
        end
        ST_TRAIL: begin
          if (adv) begin
            if (seq == SEQ_W'(TRL_LEN - 1)) begin
              seq           <= '0;
              header_sent   <= 1'b0;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              seq <= seq + SEQ_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emitting) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emitting) begin
      out_byte       <= cur_byte;
      packet_end     <= cur_end;
      label_overflow <= cur_end && overflow_seen;
    end
  end

endmodule

/* src/dnsqe_checker.sv */
`timescale 1ns / 1ps

module dnsqe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        name_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        packet_end,
  input logic        label_overflow
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output word changed while stalled");

  // overflow is reported only on the final byte
  a_ovf_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && label_overflow |-> packet_end)
    else $error("label_overflow off the final byte");

  // reset leaves the output empty and the input open
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output not empty after reset");

  // after the last character the input is refused while the message drains
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && name_end |=> !in_ready)
    else $error("input taken back to back after the last character");

endmodule

bind dns_query_name_encoder_core dnsqe_checker u_dnsqe_checker (.*);
